// ===== sv/rvl_pkg.sv =====
`timescale 1ns / 1ps

package rvl_pkg;

  localparam int MAX_ROWS_DEF       = 256;
  localparam int MAX_COLS_DEF       = 256;
  localparam int ELEVATION_BITS_DEF = 16;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_USED_ROWS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_USED_COLS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VIEW_COL    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VIEW_ROW    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_VIEW_HEIGHT = 3'd4;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic               op;
    logic [7:0]         cell_row;
    logic [7:0]         cell_col;
    logic signed [15:0] elevation;
  } in_word_t;

  typedef struct packed {
    logic visible;
    logic out_of_range;
  } out_word_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic sq_init;
    logic sq_step;
    logic scale;
    logic issue;
    logic out_ld;
  } rvl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic in_query;
    logic oor;
    logic sq_done;
    logic steps_zero;
    logic last_issue;
    logic blocked;
    logic pipe_empty;
    logic out_free;
  } rvl_stat_t;

endpackage

// ===== sv/rvl_ctrl.sv =====
`timescale 1ns / 1ps

module rvl_ctrl import rvl_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output rvl_cmd_t  cmd,
  input  rvl_stat_t st
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CHECK = 7'b0000010,
    S_SQRT  = 7'b0000100,
    S_SCALE = 7'b0001000,
    S_WALK  = 7'b0010000,
    S_DRAIN = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        cmd.accept = in_valid;
        if (in_valid && st.in_query) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.sq_init = 1'b1;
        state_nxt   = st.oor ? S_DONE : S_SQRT;
      end
      S_SQRT: begin
        if (st.sq_done) begin
          state_nxt = S_SCALE;
        end else begin
          cmd.sq_step = 1'b1;
        end
      end
      S_SCALE: begin
        if (st.steps_zero) begin
          state_nxt = S_DONE;
        end else begin
          cmd.scale = 1'b1;
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        if (st.blocked) begin
          state_nxt = S_DRAIN;
        end else begin
          cmd.issue = 1'b1;
          if (st.last_issue) begin
            state_nxt = S_DRAIN;
          end
        end
      end
      S_DRAIN: begin
        if (st.pipe_empty) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (st.out_free) begin
          cmd.out_ld = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/rvl_dp.sv =====
`timescale 1ns / 1ps

module rvl_dp import rvl_pkg::*; #(
  parameter int MAX_ROWS       = MAX_ROWS_DEF,
  parameter int MAX_COLS       = MAX_COLS_DEF,
  parameter int ELEVATION_BITS = ELEVATION_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  in_word_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_word_t             out_data,
  input  rvl_cmd_t              cmd,
  output rvl_stat_t             st
);

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int EB    = ELEVATION_BITS;
  localparam int VB    = (EB > 16) ? EB : 16;
  localparam int DZW   = VB + 1;
  localparam int LW    = VB + 12;
  localparam int PW    = EB + 10;
  localparam logic [AW-1:0] COLS_A = AW'(MAX_COLS);

  // configuration
  logic [8:0]         used_rows_r, used_cols_r;
  logic [7:0]         view_col_r, view_row_r;
  logic signed [15:0] view_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_rows_r   <= 9'd256;
      used_cols_r   <= 9'd256;
      view_col_r    <= '0;
      view_row_r    <= '0;
      view_height_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_USED_ROWS:   used_rows_r   <= cfg_wdata[8:0];
        CFG_USED_COLS:   used_cols_r   <= cfg_wdata[8:0];
        CFG_VIEW_COL:    view_col_r    <= cfg_wdata[7:0];
        CFG_VIEW_ROW:    view_row_r    <= cfg_wdata[7:0];
        CFG_VIEW_HEIGHT: view_height_r <= $signed(cfg_wdata[15:0]);
        default: ;
      endcase
    end
  end

  // query capture and range check
  logic [7:0] row_r, col_r;
  logic       oor, oor_r, blocked_r;
  logic       is_load, in_store;

  assign is_load  = cmd.accept && (in_data.op == OP_LOAD);
  assign in_store = (int'(in_data.cell_row) < MAX_ROWS) && (int'(in_data.cell_col) < MAX_COLS);

  assign oor = ({1'b0, row_r} >= used_rows_r) || (int'(row_r) >= MAX_ROWS)
            || ({1'b0, col_r} >= used_cols_r) || (int'(col_r) >= MAX_COLS)
            || ({1'b0, view_row_r} >= used_rows_r) || (int'(view_row_r) >= MAX_ROWS)
            || ({1'b0, view_col_r} >= used_cols_r) || (int'(view_col_r) >= MAX_COLS);

  always_ff @(posedge clk) begin
    if (cmd.accept && (in_data.op == OP_QUERY)) begin
      row_r <= in_data.cell_row;
      col_r <= in_data.cell_col;
    end
    if (cmd.sq_init) begin
      oor_r <= oor;
    end
  end

  // integer square root, two bits of radicand per step
  logic signed [8:0]  dx, dy;
  logic signed [17:0] dx2, dy2;
  logic [16:0]        dsq, n_r, bit_r;
  logic [17:0]        root_r, trial;

  assign dx    = $signed({1'b0, col_r}) - $signed({1'b0, view_col_r});
  assign dy    = $signed({1'b0, row_r}) - $signed({1'b0, view_row_r});
  assign dx2   = dx * dx;
  assign dy2   = dy * dy;
  assign dsq   = 17'(dx2 + dy2);
  assign trial = root_r + {1'b0, bit_r};

  always_ff @(posedge clk) begin
    if (cmd.sq_init) begin
      n_r    <= dsq;
      root_r <= '0;
      bit_r  <= 17'h10000;
    end else if (cmd.sq_step) begin
      if ({1'b0, n_r} >= trial) begin
        n_r    <= n_r - trial[16:0];
        root_r <= (root_r >> 1) + {1'b0, bit_r};
      end else begin
        root_r <= root_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  logic [8:0]         steps;
  logic signed [9:0]  steps_s;
  logic signed [10:0] steps_w;
  assign steps   = root_r[8:0];
  assign steps_s = $signed({1'b0, steps});
  assign steps_w = $signed({2'b00, steps});

  // elevation store, registered read
  logic signed [EB-1:0] mem [DEPTH];
  logic signed [EB-1:0] rd_r;
  logic [AW-1:0]        wr_addr, tgt_addr, walk_addr, rd_addr;

  assign wr_addr  = AW'(in_data.cell_row) * COLS_A + AW'(in_data.cell_col);
  assign tgt_addr = AW'(row_r) * COLS_A + AW'(col_r);
  assign rd_addr  = cmd.issue ? walk_addr : tgt_addr;

  always_ff @(posedge clk) begin
    if (is_load && in_store) begin
      mem[wr_addr] <= EB'(in_data.elevation);
    end
    rd_r <= mem[rd_addr];
  end

  // walk along the sight line; exact floor via quotient/remainder tracking
  function automatic logic [19:0] div_step(input logic signed [8:0] q,
                                           input logic signed [10:0] r,
                                           input logic signed [8:0] d,
                                           input logic signed [10:0] s);
    logic signed [10:0] t;
    logic signed [8:0]  qn;
    t  = r + d;
    qn = q;
    if (t >= s) begin
      t  = t - s;
      qn = q + 9'sd1;
    end else if (t < 11'sd0) begin
      t  = t + s;
      qn = q - 9'sd1;
    end
    return {qn, t};
  endfunction

  logic [8:0]            p_r, p_nxt;
  logic signed [8:0]     qr_r, qc_r, qr_nxt, qc_nxt;
  logic signed [10:0]    rr_r, rc_r, rr_nxt, rc_nxt;
  logic [19:0]           row_step, col_step;
  logic signed [9:0]     srow, scol;
  logic signed [DZW-1:0] dz_r;
  logic signed [LW-1:0]  lhs_r, lhs_nxt, lhs1_r, lhs2_r, prod_r;
  logic signed [25:0]    hs;
  logic signed [PW-1:0]  es;
  logic                  v1_r, v2_r;

  assign row_step = div_step(qr_r, rr_r, dy, steps_w);
  assign col_step = div_step(qc_r, rc_r, dx, steps_w);
  assign qr_nxt   = $signed(row_step[19:11]);
  assign rr_nxt   = $signed(row_step[10:0]);
  assign qc_nxt   = $signed(col_step[19:11]);
  assign rc_nxt   = $signed(col_step[10:0]);
  assign srow     = $signed({2'b00, view_row_r}) + qr_nxt;
  assign scol     = $signed({2'b00, view_col_r}) + qc_nxt;
  assign walk_addr = AW'(srow[7:0]) * COLS_A + AW'(scol[7:0]);
  assign p_nxt    = p_r + 9'd1;
  assign lhs_nxt  = lhs_r + LW'(dz_r);
  assign hs       = view_height_r * steps_s;
  assign es       = rd_r * steps_s;

  always_ff @(posedge clk) begin
    if (cmd.scale) begin
      p_r   <= '0;
      qr_r  <= '0;
      qc_r  <= '0;
      rr_r  <= '0;
      rc_r  <= '0;
      lhs_r <= LW'(hs);
      dz_r  <= DZW'(rd_r) - DZW'(view_height_r);
    end else if (cmd.issue) begin
      p_r   <= p_nxt;
      qr_r  <= qr_nxt;
      qc_r  <= qc_nxt;
      rr_r  <= rr_nxt;
      rc_r  <= rc_nxt;
      lhs_r <= lhs_nxt;
    end
    lhs1_r <= lhs_nxt;
    lhs2_r <= lhs1_r;
    prod_r <= LW'(es);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
      blocked_r <= 1'b0;
    end else begin
      v1_r <= cmd.issue;
      v2_r <= v1_r;
      if (cmd.accept && (in_data.op == OP_QUERY)) begin
        blocked_r <= 1'b0;
      end else if (v2_r && (lhs2_r < prod_r)) begin
        blocked_r <= 1'b1;
      end
    end
  end

  // result register
  logic      out_valid_r;
  out_word_t out_word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_ld) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.out_ld) begin
      out_word_r.visible      <= !oor_r && !blocked_r;
      out_word_r.out_of_range <= oor_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

  assign st.in_query   = (in_data.op == OP_QUERY);
  assign st.oor        = oor;
  assign st.sq_done    = (bit_r == '0);
  assign st.steps_zero = (steps == '0);
  assign st.last_issue = (p_nxt == steps);
  assign st.blocked    = blocked_r;
  assign st.pipe_empty = !v1_r && !v2_r;
  assign st.out_free   = !out_valid_r || !out_stall;

  a_drained: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_ld |-> (!v1_r && !v2_r))
    else $error("result loaded with samples still in flight");

  a_sqrt_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scale |-> (bit_r == '0))
    else $error("walk set up before square root finished");

  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.issue |-> (p_r < steps))
    else $error("walk issued beyond target");

  a_oor_hidden: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_word_r.out_of_range) |-> !out_word_r.visible)
    else $error("out of range word flagged visible");

endmodule

// ===== sv/raster_viewshed_line_of_sight_unit.sv =====
`timescale 1ns / 1ps
// Raster viewshed line-of-sight unit.
// Input channel (in_valid/in_stall/in_data) carries one word per item:
// a load word writes an elevation into the grid store and gives no result;
// a query word names a target cell and gives one result word on the
// output channel (out_valid/out_stall/out_data): visible, or out_of_range.
// Configuration (grid size, viewpoint, eye height) is to be written on the
// cfg_ port by the user while the unit is idle; the unit does not enforce
// this, and writes take effect at once. A query walks steps samples, where
// steps = floor(distance to target), at most 360 on a 256x256 grid; an
// out-of-range query skips the square root and the walk.
// The walk issues one store read per sample through the single read port
// and a three-stage read/multiply/compare pipeline; a blocked sample ends
// the walk early. One word is worked on at a time.
// Reset (rst_n, synchronous) returns the controller to idle, clears the
// output valid flag and restores register defaults; the grid store is not
// cleared and holds undefined data until written.
// A stalled result word stays on out_data; the unit stalls its input until
// the finished query word has been moved into the output register.
module raster_viewshed_line_of_sight_unit import rvl_pkg::*; #(
  parameter int MAX_ROWS       = MAX_ROWS_DEF,
  parameter int MAX_COLS       = MAX_COLS_DEF,
  parameter int ELEVATION_BITS = ELEVATION_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_word_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_word_t             out_data
);

  rvl_cmd_t  cmd;
  rvl_stat_t st;

  // sequencer: accept, range check, square root, walk, drain, result
  rvl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .st       (st)
  );

  // grid store, registers, square root unit and sample pipeline
  rvl_dp #(
    .MAX_ROWS       (MAX_ROWS),
    .MAX_COLS       (MAX_COLS),
    .ELEVATION_BITS (ELEVATION_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cmd       (cmd),
    .st        (st)
  );

endmodule

// ===== dv/raster_viewshed_line_of_sight_unit_tb.sv =====
`timescale 1ns / 1ps
module raster_viewshed_line_of_sight_unit_tb;
  import rvl_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int HOLD_CYCLES = 3000;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_stall;
  in_word_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_word_t             out_data;

  raster_viewshed_line_of_sight_unit dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // mirror of the grid and the registers
  logic signed [15:0] grid_elev [0:65535];
  bit                 grid_written [0:65535];
  logic [8:0]         m_rows, m_cols;
  logic [7:0]         m_vcol, m_vrow;
  logic signed [15:0] m_vh;

  out_word_t sight_results_q[$];
  int        n_errors;
  int        gap_pct;
  int        stall_pct;
  int        hold_left;
  int        cycle_cnt;

  // directed table: typed result only where it is obvious
  typedef struct {
    logic               op;
    logic [7:0]         row;
    logic [7:0]         col;
    logic signed [15:0] elev;
    bit                 typed;
    out_word_t          res;
  } dir_row_t;

  dir_row_t dir_tab [] = '{
    '{OP_LOAD,  8'd3,   8'd2,   16'sd0,      0, '{1'b0, 1'b0}},
    '{OP_QUERY, 8'd3,   8'd2,   16'sd0,      1, '{1'b1, 1'b0}}, // target is the viewpoint
    '{OP_QUERY, 8'd16,  8'd0,   16'sd0,      1, '{1'b0, 1'b1}}, // row just past grid
    '{OP_QUERY, 8'd0,   8'd16,  16'sd0,      1, '{1'b0, 1'b1}}, // col just past grid
    '{OP_QUERY, 8'd255, 8'd255, -16'sd1,     1, '{1'b0, 1'b1}},
    '{OP_LOAD,  8'd0,   8'd0,   16'sd32767,  0, '{1'b0, 1'b0}},
    '{OP_QUERY, 8'd0,   8'd0,   16'sd0,      0, '{1'b0, 1'b0}},
    '{OP_LOAD,  8'd15,  8'd15,  -16'sd32768, 0, '{1'b0, 1'b0}},
    '{OP_QUERY, 8'd15,  8'd15,  16'sd0,      0, '{1'b0, 1'b0}},
    '{OP_LOAD,  8'd255, 8'd255, -16'sd1,     0, '{1'b0, 1'b0}}, // outside used grid, kept
    '{OP_LOAD,  8'd170, 8'd85,  16'sh5555,   0, '{1'b0, 1'b0}},
    '{OP_LOAD,  8'd85,  8'd170, -16'sh5556,  0, '{1'b0, 1'b0}},
    '{OP_LOAD,  8'd3,   8'd9,   16'sd200,    0, '{1'b0, 1'b0}},
    '{OP_QUERY, 8'd3,   8'd15,  16'sd0,      0, '{1'b0, 1'b0}},
    '{OP_QUERY, 8'd15,  8'd0,   16'sd0,      0, '{1'b0, 1'b0}},
    '{OP_QUERY, 8'd0,   8'd15,  16'sd0,      0, '{1'b0, 1'b0}},
    '{OP_QUERY, 8'd9,   8'd7,   16'sd0,      0, '{1'b0, 1'b0}}
  };

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic int unsigned floor_sqrt(int unsigned n);
    int unsigned r;
    r = 0;
    while ((r + 1) * (r + 1) <= n) r++;
    return r;
  endfunction

  function automatic longint floor_ratio(longint num, longint den);
    if (num >= 0) return num / den;
    return -((-num + den - 1) / den);
  endfunction

  function automatic int unsigned eff_rows();
    return (m_rows > 9'd256) ? 256 : int'(m_rows);
  endfunction

  function automatic int unsigned eff_cols();
    return (m_cols > 9'd256) ? 256 : int'(m_cols);
  endfunction

  function automatic bit query_off_grid(logic [7:0] row, logic [7:0] col);
    return row >= eff_rows() || col >= eff_cols() ||
           m_vrow >= eff_rows() || m_vcol >= eff_cols();
  endfunction

  // cells a query may read: target plus every sample on the line
  function automatic void sight_cells(input logic [7:0] row, input logic [7:0] col,
                                      ref int unsigned cells[$]);
    longint dx, dy, s, pr, pc;
    cells.delete();
    if (query_off_grid(row, col)) return;
    cells.push_back(row * 256 + col);
    dx = longint'(col) - longint'(m_vcol);
    dy = longint'(row) - longint'(m_vrow);
    s  = floor_sqrt(int'(dx * dx + dy * dy));
    for (longint p = 1; p <= s; p++) begin
      pr = m_vrow + floor_ratio(p * dy, s);
      pc = m_vcol + floor_ratio(p * dx, s);
      cells.push_back(int'(pr * 256 + pc));
    end
  endfunction

  function automatic out_word_t predict_sight(logic [7:0] row, logic [7:0] col);
    longint dx, dy, s, h, z, dz, pr, pc, e;
    if (query_off_grid(row, col)) return '{1'b0, 1'b1};
    dx = longint'(col) - longint'(m_vcol);
    dy = longint'(row) - longint'(m_vrow);
    s  = floor_sqrt(int'(dx * dx + dy * dy));
    h  = m_vh;
    z  = grid_elev[row * 256 + col];
    dz = z - h;
    for (longint p = 1; p <= s; p++) begin
      pr = m_vrow + floor_ratio(p * dy, s);
      pc = m_vcol + floor_ratio(p * dx, s);
      if (pr < 0 || pc < 0 || pr >= eff_rows() || pc >= eff_cols()) continue;
      e = grid_elev[pr * 256 + pc];
      if (h * s + p * dz < e * s) return '{1'b0, 1'b0};
    end
    return '{1'b1, 1'b0};
  endfunction

  function automatic logic signed [15:0] rand_elev();
    case ($urandom_range(4))
      0:       return 16'($urandom);
      1:       return $urandom_range(1) ? 16'sd32767 : -16'sd32768;
      default: return $signed(16'($urandom_range(400))) - 16'sd200;
    endcase
  endfunction

  // one word across the input channel; the mirror is updated on acceptance
  task automatic send_word(in_word_t w, bit typed, out_word_t res);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (w.op == OP_LOAD) begin
      grid_elev[w.cell_row * 256 + w.cell_col]    = w.elevation;
      grid_written[w.cell_row * 256 + w.cell_col] = 1'b1;
    end else begin
      sight_results_q.push_back(typed ? res : predict_sight(w.cell_row, w.cell_col));
    end
  endtask

  // loads any unwritten cell on the line first, so no undefined entry is read
  task automatic send_item(in_word_t w, bit typed, out_word_t res);
    int unsigned cells[$];
    in_word_t    ld;
    if (w.op == OP_QUERY) begin
      sight_cells(w.cell_row, w.cell_col, cells);
      foreach (cells[i]) begin
        if (!grid_written[cells[i]]) begin
          ld.op        = OP_LOAD;
          ld.cell_row  = 8'(cells[i] / 256);
          ld.cell_col  = 8'(cells[i] % 256);
          ld.elevation = rand_elev();
          send_word(ld, 1'b0, '0);
        end
      end
    end
    send_word(w, typed, res);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sight_results_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= d;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      CFG_USED_ROWS:   m_rows = d[8:0];
      CFG_USED_COLS:   m_cols = d[8:0];
      CFG_VIEW_COL:    m_vcol = d[7:0];
      CFG_VIEW_ROW:    m_vrow = d[7:0];
      CFG_VIEW_HEIGHT: m_vh   = d;
      default: ;
    endcase
  endtask

  task automatic query_once(logic [7:0] row, logic [7:0] col);
    in_word_t w;
    w = '{OP_QUERY, row, col, 16'($urandom)};
    send_item(w, 1'b0, '0);
  endtask

  // result checker: sampled at the edge, so values are the pre-edge ones
  always @(posedge clk) begin
    out_word_t want;
    cycle_cnt <= cycle_cnt + 1;
    if (rst_n && out_valid && !out_stall) begin
      if (sight_results_q.size() == 0) begin
        $display("%0t: unexpected result word vis=%b oor=%b", $time,
                 out_data.visible, out_data.out_of_range);
        n_errors++;
      end else begin
        want = sight_results_q.pop_front();
        if (out_data.visible !== want.visible) begin
          $display("%0t: visible mismatch expected %b actual %b", $time,
                   want.visible, out_data.visible);
          n_errors++;
        end
        if (out_data.out_of_range !== want.out_of_range) begin
          $display("%0t: out_of_range mismatch expected %b actual %b", $time,
                   want.out_of_range, out_data.out_of_range);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver: random stall, or a long hold-off when asked
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  initial begin
    in_word_t    w;
    int unsigned er, ec, n_items;
    cycle_cnt = 0;
    n_errors  = 0;
    gap_pct   = 0;
    stall_pct = 0;
    hold_left = 0;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_valid  = 1'b0;
    in_data   = '0;
    m_rows = 9'd256; m_cols = 9'd256; m_vcol = 8'd0; m_vrow = 8'd0; m_vh = 16'sd0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset defaults: far corner on the full grid, then the viewpoint cell
    query_once(8'd255, 8'd255);
    query_once(8'd0, 8'd0);
    drain();

    // directed table on a 16x16 grid
    cfg_write(CFG_USED_ROWS, 16'd16);
    cfg_write(CFG_USED_COLS, 16'd16);
    cfg_write(CFG_VIEW_COL, 16'd2);
    cfg_write(CFG_VIEW_ROW, 16'd3);
    cfg_write(CFG_VIEW_HEIGHT, 16'd50);
    foreach (dir_tab[i]) begin
      w = '{dir_tab[i].op, dir_tab[i].row, dir_tab[i].col, dir_tab[i].elev};
      send_item(w, dir_tab[i].typed, dir_tab[i].res);
    end
    drain();

    // viewpoint outside the grid
    cfg_write(CFG_VIEW_COL, 16'd20);
    send_item('{OP_QUERY, 8'd0, 8'd0, 16'sd0}, 1'b1, '{1'b0, 1'b1});
    drain();
    // zero size grid
    cfg_write(CFG_VIEW_COL, 16'd0);
    cfg_write(CFG_USED_ROWS, 16'd0);
    send_item('{OP_QUERY, 8'd0, 8'd0, 16'sd0}, 1'b1, '{1'b0, 1'b1});
    drain();
    // sizes above the store clamp to it; height at both extremes
    cfg_write(CFG_USED_ROWS, 16'h01FF);
    cfg_write(CFG_USED_COLS, 16'd300);
    cfg_write(CFG_VIEW_HEIGHT, 16'h8000);
    query_once(8'd255, 8'd40);
    drain();
    cfg_write(CFG_VIEW_HEIGHT, 16'h7FFF);
    query_once(8'd255, 8'd40);
    query_once(8'd200, 8'd255);
    drain();

    // random phases: gap/stall pairs cycle through the four idling modes
    // long sight lines pull in loads for every unwritten cell on them, so
    // the wide-grid phases are kept short
    for (int ph = 0; ph < 6; ph++) begin
      case (ph % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 66; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 66; end
        default: begin gap_pct = 22; stall_pct = 22; end
      endcase
      n_items = 220;
      if (ph == 5) begin
        cfg_write(CFG_USED_ROWS, 16'd256);
        cfg_write(CFG_USED_COLS, 16'd256);
        n_items = 8;
      end else if (ph == 4) begin
        cfg_write(CFG_USED_ROWS, 16'($urandom_range(257, 511)));
        cfg_write(CFG_USED_COLS, 16'($urandom_range(2, 6)));
        n_items = 120;
      end else begin
        cfg_write(CFG_USED_ROWS, 16'($urandom_range(1, 24)));
        cfg_write(CFG_USED_COLS, 16'($urandom_range(1, 24)));
      end
      er = eff_rows();
      ec = eff_cols();
      if ($urandom_range(9) == 0) begin
        cfg_write(CFG_VIEW_COL, 16'($urandom_range(255)));
        cfg_write(CFG_VIEW_ROW, 16'($urandom_range(255)));
      end else begin
        cfg_write(CFG_VIEW_COL, 16'($urandom_range(ec - 1)));
        cfg_write(CFG_VIEW_ROW, 16'($urandom_range(er - 1)));
      end
      cfg_write(CFG_VIEW_HEIGHT, 16'(rand_elev()));
      // pressure: output held off while words keep coming
      if (ph == 2) hold_left = HOLD_CYCLES;
      for (int n = 0; n < n_items; n++) begin
        w.elevation = rand_elev();
        if ($urandom_range(4) == 0) begin
          w.op = OP_QUERY;
          w.cell_row = 8'($urandom);
          w.cell_col = 8'($urandom);
        end else begin
          w.op = ($urandom_range(99) < 30) ? OP_LOAD : OP_QUERY;
          w.cell_row = 8'($urandom_range(er - 1));
          w.cell_col = 8'($urandom_range(ec - 1));
        end
        if (w.op == OP_LOAD && $urandom_range(4) == 0) begin
          w.cell_row = 8'($urandom);
          w.cell_col = 8'($urandom);
        end
        send_item(w, 1'b0, '0);
      end
      drain();
    end

    repeat (400) @(posedge clk);
    if (n_errors == 0 && sight_results_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
